[rtl/gdc_pkg.sv]
// Package for the gradient direction classifier.
// Holds sizes, direction codes, register indexes, coefficient bundle and helpers.
// No dependencies.
package gdc_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;
	localparam int BORDER     = 4;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int LINES      = 4;
	localparam int PIX_W      = 24;
	localparam int LANES      = 3;
	localparam int LANE_LAT   = 6;
	localparam int CNT_W      = $clog2(LANE_LAT);

	typedef enum logic [2:0] {
		DIR_NONE = 3'd0,
		DIR_VERT = 3'd1,
		DIR_HORZ = 3'd2,
		DIR_MAIN = 3'd3,
		DIR_ANTI = 3'd4
	} dir_t;

	typedef enum logic [2:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_DIAG_GAIN    = 3'd2,
		REG_ACT_FACTOR   = 3'd3,
		REG_DOM_MARGIN   = 3'd4,
		REG_CROSS_MARGIN = 3'd5,
		REG_VOTE_THRESH  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [9:0] diag_gain;
		logic [9:0] activity_factor;
		logic [8:0] dominance_margin;
		logic [8:0] cross_margin;
	} coef_t;

	function automatic logic [7:0] absd(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

[rtl/gdc_ram.sv]
// Generic simple dual-port RAM with registered read.
// One write port, one read port; no dependencies.
module gdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/gdc_lane.sv]
// One channel lane: activity and directional sums, scaled products, one vote.
// Depends on gdc_pkg. Six register stages, no flow control.
module gdc_lane import gdc_pkg::*; (
	input  logic             clk,
	input  logic [24:0][7:0] win,
	input  coef_t            coef,
	output dir_t             vote
);

	typedef struct packed {
		logic [18:0] msv;
		logic [18:0] msh;
		logic [18:0] msm;
		logic [18:0] mss;
		logic [19:0] gsv;
		logic [19:0] gsh;
		logic [18:0] csm;
		logic [18:0] css;
		logic [9:0]  sv;
		logic [9:0]  sh;
		logic [9:0]  sm;
		logic [9:0]  ss;
	} term_t;

	typedef struct packed {
		logic [28:0] mgsv;
		logic [28:0] mgsh;
		logic [28:0] gcsv;
		logic [28:0] gcsh;
	} prod_t;

	function automatic int wi(input int di, input int dj);
		return (2 + di) * 5 + 2 + dj;
	endfunction

	logic [12:0] ax, dg;
	logic [9:0]  sv, sh, sm, ss;

	logic [12:0] ax_s1, dg_s1;
	logic [9:0]  sv_s1, sh_s1, sm_s1, ss_s1;
	logic [22:0] gax_s2;
	logic [12:0] dg_s2;
	term_t       t_s2, t_s3, t_s4, t_s5;
	logic [23:0] actin_s3;
	prod_t       p_s3, p_s4, p_s5;
	logic [33:0] aact_s4;
	logic [35:0] act;
	logic [3:0]  strong_s5;
	dir_t        vote_s6;
	dir_t        vote_c;

	// Sum absolute differences over the window
	always_comb begin
		ax = '0;
		dg = '0;
		sv = '0;
		sh = '0;
		sm = '0;
		ss = '0;
		for (int k = -1; k <= 1; k++) begin
			ax = ax + 13'(absd(win[wi(0, k)], win[wi(-2, k)]));
			ax = ax + 13'(absd(win[wi(1, k)], win[wi(-1, k)]));
			ax = ax + 13'(absd(win[wi(2, k)], win[wi(0, k)]));
			ax = ax + 13'(absd(win[wi(k, 0)], win[wi(k, -2)]));
			ax = ax + 13'(absd(win[wi(k, 1)], win[wi(k, -1)]));
			ax = ax + 13'(absd(win[wi(k, 2)], win[wi(k, 0)]));
			sv = sv + 10'(absd(win[wi(-1, k)], win[wi(1, k)]));
			sh = sh + 10'(absd(win[wi(k, -1)], win[wi(k, 1)]));
		end
		for (int k = -2; k <= 0; k++) begin
			dg = dg + 13'(absd(win[wi(k, -2)], win[wi(k + 2, 0)]));
			dg = dg + 13'(absd(win[wi(k, -1)], win[wi(k + 2, 1)]));
			dg = dg + 13'(absd(win[wi(k, 0)], win[wi(k + 2, 2)]));
		end
		for (int k = 0; k <= 2; k++) begin
			dg = dg + 13'(absd(win[wi(k, -2)], win[wi(k - 2, 0)]));
			dg = dg + 13'(absd(win[wi(k, -1)], win[wi(k - 2, 1)]));
			dg = dg + 13'(absd(win[wi(k, 0)], win[wi(k - 2, 2)]));
			sm = sm + 10'(absd(win[wi(k - 2, k)], win[wi(k, k - 2)]));
			ss = ss + 10'(absd(win[wi(k - 2, -k)], win[wi(k, 2 - k)]));
		end
	end

	// Total activity scaled by three and the activity factor
	assign act = 36'(aact_s4) + {1'b0, aact_s4, 1'b0};

	// Dominance cascade: first matching direction decides
	always_comb begin
		vote_c = DIR_NONE;
		if (t_s5.msv > {1'b0, t_s5.sh, 8'b0} && p_s5.mgsv > {3'b0, t_s5.sm, 16'b0}
				&& p_s5.mgsv > {3'b0, t_s5.ss, 16'b0}) begin
			if (strong_s5[0] && t_s5.gsh < 20'(t_s5.csm) && t_s5.gsh < 20'(t_s5.css))
				vote_c = DIR_VERT;
		end else if (t_s5.msh > {1'b0, t_s5.sv, 8'b0} && p_s5.mgsh > {3'b0, t_s5.sm, 16'b0}
				&& p_s5.mgsh > {3'b0, t_s5.ss, 16'b0}) begin
			if (strong_s5[1] && t_s5.gsv < 20'(t_s5.csm) && t_s5.gsv < 20'(t_s5.css))
				vote_c = DIR_HORZ;
		end else if (20'(t_s5.msm) > t_s5.gsh && 20'(t_s5.msm) > t_s5.gsv
				&& t_s5.msm > {1'b0, t_s5.ss, 8'b0}) begin
			if (strong_s5[2] && p_s5.gcsv > {3'b0, t_s5.ss, 16'b0}
					&& p_s5.gcsh > {3'b0, t_s5.ss, 16'b0})
				vote_c = DIR_MAIN;
		end else if (20'(t_s5.mss) > t_s5.gsh && 20'(t_s5.mss) > t_s5.gsv
				&& t_s5.mss > {1'b0, t_s5.sm, 8'b0}) begin
			if (strong_s5[3] && p_s5.gcsv > {3'b0, t_s5.sm, 16'b0}
					&& p_s5.gcsh > {3'b0, t_s5.sm, 16'b0})
				vote_c = DIR_ANTI;
		end
	end

	// Advance the lane pipeline
	always_ff @(posedge clk) begin
		// sums
		ax_s1 <= ax;
		dg_s1 <= dg;
		sv_s1 <= sv;
		sh_s1 <= sh;
		sm_s1 <= sm;
		ss_s1 <= ss;
		// first products
		gax_s2   <= 23'(coef.diag_gain) * 23'(ax_s1);
		dg_s2    <= dg_s1;
		t_s2.msv <= 19'(coef.dominance_margin) * 19'(sv_s1);
		t_s2.msh <= 19'(coef.dominance_margin) * 19'(sh_s1);
		t_s2.msm <= 19'(coef.dominance_margin) * 19'(sm_s1);
		t_s2.mss <= 19'(coef.dominance_margin) * 19'(ss_s1);
		t_s2.gsv <= 20'(coef.diag_gain) * 20'(sv_s1);
		t_s2.gsh <= 20'(coef.diag_gain) * 20'(sh_s1);
		t_s2.csm <= 19'(coef.cross_margin) * 19'(sm_s1);
		t_s2.css <= 19'(coef.cross_margin) * 19'(ss_s1);
		t_s2.sv  <= sv_s1;
		t_s2.sh  <= sh_s1;
		t_s2.sm  <= sm_s1;
		t_s2.ss  <= ss_s1;
		// second products
		t_s3      <= t_s2;
		p_s3.mgsv <= 29'(t_s2.msv) * 29'(coef.diag_gain);
		p_s3.mgsh <= 29'(t_s2.msh) * 29'(coef.diag_gain);
		p_s3.gcsv <= 29'(t_s2.gsv) * 29'(coef.cross_margin);
		p_s3.gcsh <= 29'(t_s2.gsh) * 29'(coef.cross_margin);
		actin_s3  <= 24'(gax_s2) + {3'b0, dg_s2, 8'b0};
		// activity factor
		t_s4    <= t_s3;
		p_s4    <= p_s3;
		aact_s4 <= 34'(coef.activity_factor) * 34'(actin_s3);
		// strength tests
		t_s5 <= t_s4;
		p_s5 <= p_s4;
		strong_s5[0] <= {4'b0, 16'(t_s4.sv) * 16'd36, 16'b0} > act;
		strong_s5[1] <= {4'b0, 16'(t_s4.sh) * 16'd36, 16'b0} > act;
		strong_s5[2] <= {4'b0, 16'(t_s4.sm) * 16'd36, 16'b0} > act;
		strong_s5[3] <= {4'b0, 16'(t_s4.ss) * 16'd36, 16'b0} > act;
		// vote
		vote_s6 <= vote_c;
	end

	assign vote = vote_s6;

endmodule

[rtl/gdc_merge.sv]
// Vote merge: counts the lane votes and picks the first direction at threshold.
// Depends on gdc_pkg.
module gdc_merge import gdc_pkg::*; (
	input  dir_t       votes [LANES],
	input  logic [1:0] vote_threshold,
	input  logic       interior,
	output dir_t       direction_class
);

	logic [1:0] cnt [1:4];

	// Count votes per direction
	always_comb begin
		for (int d = 1; d <= 4; d++) begin
			cnt[d] = '0;
			for (int l = 0; l < LANES; l++) begin
				if (votes[l] == dir_t'(3'(d)))
					cnt[d] = cnt[d] + 2'd1;
			end
		end
	end

	// Take the first direction in priority order; border gives none
	always_comb begin
		direction_class = DIR_NONE;
		if (interior) begin
			if (cnt[1] >= vote_threshold)
				direction_class = DIR_VERT;
			else if (cnt[2] >= vote_threshold)
				direction_class = DIR_HORZ;
			else if (cnt[3] >= vote_threshold)
				direction_class = DIR_MAIN;
			else if (cnt[4] >= vote_threshold)
				direction_class = DIR_ANTI;
		end
	end

endmodule

[rtl/gradient_direction_classifier.sv]
// Top level of the gradient direction classifier.
// Depends on gdc_pkg, gdc_ram, gdc_lane and gdc_merge.
//
// Input stream: one pixel per request, s_tdata = three 8-bit samples, s_tuser
// = frame start. Output stream: one result per pixel at row >= 2 and col >= 2,
// classifying the pixel two rows and two columns back. Other pixels give none.
// Configuration must be written over the APB port only while the block is
// idle; the block itself does not enforce this. Each pixel passes through a
// line-store read, a window load and write back, six stages of the three
// channel lanes (multiplier chain for the activity threshold) and the load
// of the output register. s_tready is high only in the idle state. A result
// sits in the output register while m_tready is low, and the next pixel may
// be accepted meanwhile, but its result waits for that register to empty.
// Reset clears counters, control and registers to their defaults; line
// store and window contents are not cleared, since stale data only reaches
// border pixels, which always give class 0.
module gradient_direction_classifier import gdc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // chan_a[7:0], chan_b[15:8], chan_c[23:16]
	input  logic        s_tuser,   // frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // out_row[10:0], out_col[21:11], direction_class[24:22]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CALC,
		ST_DONE
	} state_t;

	state_t          state_q;
	logic [CNT_W-1:0] cnt_q;

	logic [11:0] image_width_q, image_height_q;
	coef_t       coef_q;
	logic [1:0]  vote_threshold_q;

	logic [COL_W-1:0] col_q, cur_col_q, ocol_q;
	logic [ROW_W-1:0] row_q, orow_q;
	logic [PIX_W-1:0] pix_q;
	logic             emit_q, interior_q;

	logic [PIX_W-1:0] win_q [25];
	logic [24:0][7:0] win_ch [LANES];
	dir_t             votes [LANES];
	dir_t             cls;

	logic             out_valid_q;
	logic [ROW_W-1:0] out_row_q;
	logic [COL_W-1:0] out_col_q;
	dir_t             out_cls_q;

	logic [11:0] eff_w, eff_h;
	logic [11:0] cc0, rc0, cc1, rc1, rc2, nc, nr, ii, jj;
	logic        s_acc, cfg_wr, out_load;
	logic [LINES*PIX_W-1:0] rd_data;

	// Effective frame size
	always_comb begin
		eff_w = (image_width_q == 12'd0) ? 12'd1 :
			(image_width_q > 12'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : image_width_q;
		eff_h = (image_height_q == 12'd0) ? 12'd1 :
			(image_height_q > 12'(MAX_HEIGHT)) ? 12'(MAX_HEIGHT) : image_height_q;
	end

	// Position of the incoming pixel and the next one
	always_comb begin
		cc0 = s_tuser ? 12'd0 : 12'(col_q);
		rc0 = s_tuser ? 12'd0 : 12'(row_q);
		cc1 = cc0;
		rc1 = rc0;
		if (cc0 >= eff_w) begin
			cc1 = 12'd0;
			rc1 = rc0 + 12'd1;
		end
		rc2 = (rc1 >= eff_h) ? 12'd0 : rc1;
		nc = cc1 + 12'd1;
		nr = rc2;
		if (nc >= eff_w) begin
			nc = 12'd0;
			nr = rc2 + 12'd1;
			if (nr >= eff_h)
				nr = 12'd0;
		end
		ii = rc2 - 12'd2;
		jj = cc1 - 12'd2;
	end

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign out_load = (state_q == ST_DONE) && emit_q && (!out_valid_q || m_tready);

	// Line store: one word holds the four stored lines of a column
	gdc_ram #(
		.WIDTH(LINES * PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk     (clk),
		.wr_en   (state_q == ST_LOAD),
		.wr_addr (cur_col_q),
		.wr_data ({pix_q, rd_data[LINES*PIX_W-1:PIX_W]}),
		.rd_en   (s_acc),
		.rd_addr (cc1[COL_W-1:0]),
		.rd_data (rd_data)
	);

	// Shift the window in when the line store word arrives
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			for (int r = 0; r < 5; r++) begin
				for (int c = 0; c < 4; c++)
					win_q[r * 5 + c] <= win_q[r * 5 + c + 1];
			end
			for (int r = 0; r < 4; r++)
				win_q[r * 5 + 4] <= rd_data[r * PIX_W +: PIX_W];
			win_q[24] <= pix_q;
		end
	end

	// Split the window per channel
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			for (int e = 0; e < 25; e++)
				win_ch[l][e] = win_q[e][l * 8 +: 8];
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		gdc_lane u_lane (
			.clk  (clk),
			.win  (win_ch[l]),
			.coef (coef_q),
			.vote (votes[l])
		);
	end

	gdc_merge u_merge (
		.votes          (votes),
		.vote_threshold (vote_threshold_q),
		.interior       (interior_q),
		.direction_class(cls)
	);

	// Capture the request and its position
	always_ff @(posedge clk) begin
		if (s_acc) begin
			pix_q      <= s_tdata;
			cur_col_q  <= cc1[COL_W-1:0];
			orow_q     <= ii[ROW_W-1:0];
			ocol_q     <= jj[COL_W-1:0];
			interior_q <= (ii >= 12'(BORDER)) && (ii + 12'(BORDER) < eff_h)
				&& (jj >= 12'(BORDER)) && (jj + 12'(BORDER) < eff_w);
		end
	end

	// Sequencer, counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			emit_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_row_q   <= '0;
			out_col_q   <= '0;
			out_cls_q   <= DIR_NONE;
		end else begin
			// hold the result until it is taken
			out_valid_q <= out_load || (out_valid_q && !m_tready);
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						col_q   <= nc[COL_W-1:0];
						row_q   <= nr[ROW_W-1:0];
						emit_q  <= (rc2 >= 12'd2) && (cc1 >= 12'd2);
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					cnt_q   <= '0;
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(LANE_LAT - 1))
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!emit_q) begin
						state_q <= ST_IDLE;
					end else if (out_load) begin
						out_row_q   <= orow_q;
						out_col_q   <= ocol_q;
						out_cls_q   <= cls;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_cls_q, out_col_q, out_row_q};

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q           <= 12'd640;
			image_height_q          <= 12'd480;
			coef_q.diag_gain        <= 10'd361;
			coef_q.activity_factor  <= 10'd282;
			coef_q.dominance_margin <= 9'd230;
			coef_q.cross_margin     <= 9'd230;
			vote_threshold_q        <= 2'd2;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[4:2]))
				REG_IMAGE_WIDTH:  image_width_q           <= pwdata[11:0];
				REG_IMAGE_HEIGHT: image_height_q          <= pwdata[11:0];
				REG_DIAG_GAIN:    coef_q.diag_gain        <= pwdata[9:0];
				REG_ACT_FACTOR:   coef_q.activity_factor  <= pwdata[9:0];
				REG_DOM_MARGIN:   coef_q.dominance_margin <= pwdata[8:0];
				REG_CROSS_MARGIN: coef_q.cross_margin     <= pwdata[8:0];
				REG_VOTE_THRESH:  vote_threshold_q        <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	// Register read back
	always_comb begin
		case (reg_idx_t'(paddr[4:2]))
			REG_IMAGE_WIDTH:  prdata = {20'b0, image_width_q};
			REG_IMAGE_HEIGHT: prdata = {20'b0, image_height_q};
			REG_DIAG_GAIN:    prdata = {22'b0, coef_q.diag_gain};
			REG_ACT_FACTOR:   prdata = {22'b0, coef_q.activity_factor};
			REG_DOM_MARGIN:   prdata = {23'b0, coef_q.dominance_margin};
			REG_CROSS_MARGIN: prdata = {23'b0, coef_q.cross_margin};
			REG_VOTE_THRESH:  prdata = {30'b0, vote_threshold_q};
			default:          prdata = 32'b0;
		endcase
	end

endmodule
